// ===== hw/rtl/token_scanner_assert.svh =====
// Assertion macros for the token scanner RTL, used by tsc_fifo.
// Needs clk_i and rst_ni in the module that uses them.
`ifndef TOKEN_SCANNER_ASSERT_SVH
`define TOKEN_SCANNER_ASSERT_SVH

// A property that must hold at every clock edge out of reset.
`define TSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// When cond holds, prop must hold in the next cycle.
`define TSC_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== hw/rtl/tsc_pkg.sv =====
// Types, codes and character helpers for the token scanner.
// No dependencies; used by every module of the block.
`default_nettype none

package tsc_pkg;

  // Default width of character positions and token lengths.
  localparam int POS_WIDTH = 16;

  // Depth of the result queue.
  localparam int RES_DEPTH = 4;

  // Characters with a meaning of their own.
  localparam logic [7:0] CHAR_QUOTE  = 8'h22;
  localparam logic [7:0] CHAR_EQUAL  = 8'h3D;
  localparam logic [7:0] CHAR_LPAREN = 8'h28;
  localparam logic [7:0] CHAR_RPAREN = 8'h29;
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LOW_L  = 8'h6C;
  localparam logic [7:0] CHAR_LOW_P  = 8'h70;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_WORD = 2'd1,
    MODE_NUM  = 2'd2,
    MODE_STR  = 2'd3
  } tsc_mode_e;

  typedef enum logic [1:0] {
    KW_NONE  = 2'd0,
    KW_LET   = 2'd1,
    KW_PRINT = 2'd2
  } tsc_kw_e;

  typedef enum logic [3:0] {
    KIND_LET    = 4'd0,
    KIND_PRINT  = 4'd1,
    KIND_IDENT  = 4'd2,
    KIND_NUMBER = 4'd3,
    KIND_STRING = 4'd4,
    KIND_EQUAL  = 4'd5,
    KIND_LPAREN = 4'd6,
    KIND_RPAREN = 4'd7,
    KIND_PLUS   = 4'd8,
    KIND_BAD    = 4'd9
  } tsc_kind_e;

  // One token descriptor as it leaves the block.
  typedef struct packed {
    tsc_kind_e   kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [7:0]  bad;
    logic        last;
  } tsc_result_t;

  // Up to two descriptors produced by one character.
  typedef struct packed {
    logic [1:0]  num;
    tsc_result_t res0;
    tsc_result_t res1;
  } tsc_emit_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c inside {[8'h61:8'h7A]}) || (c inside {[8'h41:8'h5A]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c inside {[CHAR_TAB:CHAR_CR]});
  endfunction

  // Characters of the keyword "let" by index.
  function automatic logic [7:0] let_char(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'h6C;
      3'd1:    r = 8'h65;
      3'd2:    r = 8'h74;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Characters of the keyword "print" by index.
  function automatic logic [7:0] print_char(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'h70;
      3'd1:    r = 8'h72;
      3'd2:    r = 8'h69;
      3'd3:    r = 8'h6E;
      3'd4:    r = 8'h74;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tsc_lexer.sv =====
// Scan state and per-character token logic of the token scanner.
// Depends on tsc_pkg; one character is handled per step_i.
`default_nettype none

module tsc_lexer import tsc_pkg::*; #(
  parameter int PosWidth = POS_WIDTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] char_i,
  input  wire logic       last_i,
  output tsc_emit_t       emit_o
);

  localparam int ExtW = (PosWidth > 16) ? PosWidth : 16;

  typedef logic [PosWidth-1:0] pos_t;

  // Scan state.
  tsc_mode_e mode_q, mode_d;
  tsc_kw_e   kw_q, kw_d;
  pos_t      start_q, start_d;
  pos_t      count_q, count_d;
  pos_t      pos_q, pos_d;

  // State after the character itself, before the end-of-text close.
  tsc_mode_e mode_m;
  tsc_kw_e   kw_m;
  pos_t      start_m;
  pos_t      count_m;

  // What the character produces.
  logic       close_en;
  logic       single_en;
  logic       tail_en;
  tsc_kind_e  single_kind;
  logic [7:0] single_bad;

  function automatic pos_t grow(input pos_t cnt);
    return (cnt == '1) ? cnt : cnt + pos_t'(1);
  endfunction

  // Drop the keyword candidate if character c does not fit at index cnt.
  function automatic tsc_kw_e track_kw(input tsc_kw_e kw, input pos_t cnt,
                                       input logic [7:0] c);
    tsc_kw_e r;
    r = kw;
    if (kw == KW_LET) begin
      if ((cnt >= pos_t'(3)) || (let_char(cnt[2:0]) != c)) begin
        r = KW_NONE;
      end
    end else if (kw == KW_PRINT) begin
      if ((cnt >= pos_t'(5)) || (print_char(cnt[2:0]) != c)) begin
        r = KW_NONE;
      end
    end
    return r;
  endfunction

  function automatic tsc_kind_e pending_kind(input tsc_mode_e mode, input tsc_kw_e kw,
                                             input pos_t cnt);
    tsc_kind_e r;
    case (mode)
      MODE_WORD: begin
        if ((kw == KW_LET) && (cnt == pos_t'(3))) begin
          r = KIND_LET;
        end else if ((kw == KW_PRINT) && (cnt == pos_t'(5))) begin
          r = KIND_PRINT;
        end else begin
          r = KIND_IDENT;
        end
      end
      MODE_NUM: r = KIND_NUMBER;
      default:  r = KIND_STRING;
    endcase
    return r;
  endfunction

  // Offsets wrap to the low 16 bits of the position.
  function automatic logic [15:0] out_start(input pos_t v);
    logic [ExtW-1:0] e;
    e = ExtW'(v);
    return e[15:0];
  endfunction

  // Lengths saturate at the 16-bit limit.
  function automatic logic [15:0] out_len(input pos_t v);
    logic [ExtW-1:0] e;
    e = ExtW'(v);
    return (e > ExtW'(16'hFFFF)) ? 16'hFFFF : e[15:0];
  endfunction

  function automatic tsc_result_t make_res(input tsc_kind_e kind, input pos_t start,
                                           input pos_t len, input logic [7:0] bad);
    tsc_result_t r;
    r.kind  = kind;
    r.start = out_start(start);
    r.len   = out_len(len);
    r.bad   = bad;
    r.last  = 1'b0;
    return r;
  endfunction

  // Next scan state for the character in hand.
  always_comb begin : next_state
    logic cont;
    logic consumed;
    cont        = 1'b0;
    consumed    = 1'b0;
    mode_m      = mode_q;
    kw_m        = kw_q;
    start_m     = start_q;
    count_m     = count_q;
    close_en    = 1'b0;
    single_en   = 1'b0;
    single_kind = KIND_BAD;
    single_bad  = 8'h00;

    // Continue or close the pending token.
    case (mode_q)
      MODE_WORD, MODE_NUM: begin
        cont = (mode_q == MODE_WORD) ? is_alpha(char_i) : is_digit(char_i);
        if (cont) begin
          if (mode_q == MODE_WORD) begin
            kw_m = track_kw(kw_q, count_q, char_i);
          end
          count_m  = grow(count_q);
          consumed = 1'b1;
        end else begin
          close_en = 1'b1;
          mode_m   = MODE_IDLE;
        end
      end
      MODE_STR: begin
        if (char_i == CHAR_QUOTE) begin
          close_en = 1'b1;
          mode_m   = MODE_IDLE;
        end else begin
          count_m = grow(count_q);
        end
        consumed = 1'b1;
      end
      default: ;
    endcase

    // A character not taken by a pending token is handled from idle.
    if (!consumed) begin
      if (is_space(char_i)) begin
        mode_m = mode_m;
      end else if (is_alpha(char_i)) begin
        mode_m  = MODE_WORD;
        start_m = pos_q;
        count_m = pos_t'(1);
        if (char_i == CHAR_LOW_L) begin
          kw_m = KW_LET;
        end else if (char_i == CHAR_LOW_P) begin
          kw_m = KW_PRINT;
        end else begin
          kw_m = KW_NONE;
        end
      end else if (is_digit(char_i)) begin
        mode_m  = MODE_NUM;
        start_m = pos_q;
        count_m = pos_t'(1);
      end else if (char_i == CHAR_QUOTE) begin
        mode_m  = MODE_STR;
        start_m = pos_q + pos_t'(1);
        count_m = '0;
      end else begin
        single_en = 1'b1;
        case (char_i)
          CHAR_EQUAL:  single_kind = KIND_EQUAL;
          CHAR_LPAREN: single_kind = KIND_LPAREN;
          CHAR_RPAREN: single_kind = KIND_RPAREN;
          CHAR_PLUS:   single_kind = KIND_PLUS;
          default: begin
            single_kind = KIND_BAD;
            single_bad  = char_i;
          end
        endcase
      end
    end

    // End of text closes any pending token and restarts the offsets.
    tail_en = last_i && (mode_m != MODE_IDLE);
    start_d = start_m;
    if (last_i) begin
      mode_d  = MODE_IDLE;
      kw_d    = KW_NONE;
      count_d = '0;
      pos_d   = '0;
    end else begin
      mode_d  = mode_m;
      kw_d    = kw_m;
      count_d = count_m;
      pos_d   = pos_q + pos_t'(1);
    end
  end

  // Descriptors in the order they occur in the text.
  always_comb begin : outputs
    tsc_result_t close_r;
    tsc_result_t single_r;
    tsc_result_t tail_r;
    close_r  = make_res(pending_kind(mode_q, kw_q, count_q), start_q, count_q, 8'h00);
    single_r = make_res(single_kind, pos_q, pos_t'(1), single_bad);
    tail_r   = make_res(pending_kind(mode_m, kw_m, count_m), start_m, count_m, 8'h00);

    if (step_i) begin
      emit_o.num = 2'({1'b0, close_en}) + 2'({1'b0, single_en}) + 2'({1'b0, tail_en});
    end else begin
      emit_o.num = 2'd0;
    end

    if (close_en) begin
      emit_o.res0 = close_r;
    end else if (single_en) begin
      emit_o.res0 = single_r;
    end else begin
      emit_o.res0 = tail_r;
    end
    emit_o.res0.last = (emit_o.num == 2'd1);

    emit_o.res1      = single_en ? single_r : tail_r;
    emit_o.res1.last = 1'b1;
  end

  // State registers advance once per handled character.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      kw_q    <= KW_NONE;
      start_q <= '0;
      count_q <= '0;
      pos_q   <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      kw_q    <= kw_d;
      start_q <= start_d;
      count_q <= count_d;
      pos_q   <= pos_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tsc_fifo.sv =====
// Result queue of the token scanner: takes up to two descriptors a cycle
// and hands out one. Depends on tsc_pkg and token_scanner_assert.svh.
`default_nettype none

`include "token_scanner_assert.svh"

module tsc_fifo import tsc_pkg::*; #(
  parameter int Depth = RES_DEPTH
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire tsc_emit_t push_i,
  input  wire logic      pop_i,
  output tsc_result_t    head_o,
  output logic           valid_o,
  output logic           space_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  tsc_result_t mem_q [Depth];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic [PtrW-1:0] wr_next;

  assign wr_next = wr_ptr_q + PtrW'(1);

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_i.num);
    rd_ptr_d = rd_ptr_q + PtrW'(pop_i);
    count_d  = count_q + CntW'(push_i.num) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage; two items may land in one cycle.
  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_next] <= push_i.res1;
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign valid_o = (count_q != '0);
  assign space_o = (count_q <= CntW'(Depth - 2));

  `TSC_ASSERT(a_count_bound, count_q <= CntW'(Depth), "result queue count beyond depth")
  `TSC_ASSERT(a_push_fits, int'(count_q) + int'(push_i.num) <= Depth, "result queue overflow")
  `TSC_ASSERT(a_pop_nonempty, !pop_i || (count_q != '0), "result queue underflow")
  `TSC_ASSERT_NEXT(a_head_hold, (count_q != '0) && !pop_i, $stable(head_o), "head item changed")

endmodule

`default_nettype wire

// ===== hw/rtl/token_scanner.sv =====
// Token scanner: takes one source character per item and reports each token
// as a descriptor (kind, start offset, length). The character is registered,
// classified once the queue has room for two descriptors, and its descriptors
// are written into a four-entry result queue whose head feeds the output. A new
// character is accepted every cycle as long as the queue has room for two
// descriptors; since the output hands out one descriptor per cycle, a character
// that yields two descriptors (a word or number closed by a character that
// yields a descriptor of its own, such as a one-character token or a new token
// closed at end of text) leaves one more descriptor in the queue to drain.
// There is no clearing pass after reset. Depends on tsc_pkg, tsc_lexer and
// tsc_fifo.
`default_nettype none

module token_scanner import tsc_pkg::*; #(
  parameter int PosWidth = POS_WIDTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input characters.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  wire logic        s_axis_tlast,   // end_of_text
  // Token descriptors.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [15:0] start_offset, [31:16] token_length,
                                           // [39:32] bad_char
  output logic [3:0]       m_axis_tuser,   // [3:0] token_kind
  output logic             m_axis_tlast    // last_of_run
);

  logic        in_valid_q;
  logic [7:0]  in_char_q;
  logic        in_last_q;
  logic        step;
  logic        q_space;
  logic        q_valid;
  logic        q_pop;
  tsc_emit_t   emit;
  tsc_result_t head;

  // The held character is handled once the queue can take two items.
  assign step          = in_valid_q && q_space;
  assign s_axis_tready = !in_valid_q || step;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  tsc_lexer #(
    .PosWidth(PosWidth)
  ) u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .char_i (in_char_q),
    .last_i (in_last_q),
    .emit_o (emit)
  );

  tsc_fifo #(
    .Depth(RES_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (emit),
    .pop_i   (q_pop),
    .head_o  (head),
    .valid_o (q_valid),
    .space_o (q_space)
  );

  // Output channel straight from the queue head.
  assign q_pop         = q_valid && m_axis_tready;
  assign m_axis_tvalid = q_valid;
  assign m_axis_tdata  = {head.bad, head.len, head.start};
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;

endmodule

`default_nettype wire
